### rtl/stcs_pkg.sv
package stcs_pkg;

  // field widths
  localparam int HOUR_W   = 5;
  localparam int MIN_W    = 6;
  localparam int MOD_W    = 11;
  localparam int CLIP_W   = 7;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // time limits
  localparam logic [HOUR_W-1:0] HOUR_MAX = HOUR_W'(23);
  localparam logic [MIN_W-1:0]  MIN_MAX  = MIN_W'(59);

  // clip codes above the plain numbers
  localparam logic [CLIP_W-1:0] CLIP_HOUR_ONE  = 7'd60;
  localparam logic [CLIP_W-1:0] CLIP_HOUR_TWO  = 7'd61;
  localparam logic [CLIP_W-1:0] CLIP_MIN_ONE   = 7'd62;
  localparam logic [CLIP_W-1:0] CLIP_MIN_TWO   = 7'd63;
  localparam logic [CLIP_W-1:0] CLIP_HOUR_MANY = 7'd64;
  localparam logic [CLIP_W-1:0] CLIP_HOUR_SING = 7'd65;
  localparam logic [CLIP_W-1:0] CLIP_HOUR_FEW  = 7'd66;
  localparam logic [CLIP_W-1:0] CLIP_MIN_FEW   = 7'd67;
  localparam logic [CLIP_W-1:0] CLIP_MIN_SING  = 7'd68;
  localparam logic [CLIP_W-1:0] CLIP_MIN_MANY  = 7'd69;
  localparam logic [CLIP_W-1:0] CLIP_EXACTLY   = 7'd70;
  localparam logic [CLIP_W-1:0] CLIP_INTRO     = 7'd71;
  localparam logic [CLIP_W-1:0] CLIP_CHIMES    = 7'd72;

  // request kinds
  typedef enum logic [1:0] {
    REQ_START  = 2'd0,
    REQ_REPORT = 2'd1,
    REQ_CHECK  = 2'd2
  } req_t;

  // announcement chain position
  typedef enum logic [2:0] {
    STEP_IDLE      = 3'd0,
    STEP_HOUR_NUM  = 3'd1,
    STEP_HOUR_WORD = 3'd2,
    STEP_MIN_TENS  = 3'd3,
    STEP_MIN_UNIT  = 3'd4,
    STEP_MIN_WORD  = 3'd5
  } step_t;

  // register indexes
  typedef enum logic [2:0] {
    REG_ENABLE         = 3'd0,
    REG_WINDOW_START   = 3'd1,
    REG_WINDOW_END     = 3'd2,
    REG_TRIGGER_MINUTE = 3'd3,
    REG_LOCK_ONLY      = 3'd4,
    REG_SCHEDULED_FULL = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic              enable;
    logic [MOD_W-1:0]  window_start;
    logic [MOD_W-1:0]  window_end;
    logic [MIN_W-1:0]  trigger_minute;
    logic              lock_only;
    logic              scheduled_full;
  } cfg_t;

  typedef struct packed {
    req_t              req_type;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic              full_request;
    logic              media_busy;
    logic              calling;
    logic              unlocked;
    logic              report_matches;
    logic              report_final;
  } req_item_t;

  typedef struct packed {
    step_t             step;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
  } seq_state_t;

  typedef struct packed {
    logic              valid;
    logic [CLIP_W-1:0] clip_id;
    logic              last;
  } result_t;

  // tens digit of a minute by comparison
  function automatic logic [2:0] min_tens(input logic [MIN_W-1:0] m);
    logic [2:0] t;
    if (m >= MIN_W'(60))      t = 3'd6;
    else if (m >= MIN_W'(50)) t = 3'd5;
    else if (m >= MIN_W'(40)) t = 3'd4;
    else if (m >= MIN_W'(30)) t = 3'd3;
    else if (m >= MIN_W'(20)) t = 3'd2;
    else if (m >= MIN_W'(10)) t = 3'd1;
    else                      t = 3'd0;
    return t;
  endfunction

endpackage

### rtl/stcs_cfg.sv
module stcs_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [stcs_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [stcs_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [stcs_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                               cfg_pready,
  output stcs_pkg::cfg_t                     cfg
);

  stcs_pkg::cfg_t     cfg_r;
  stcs_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx        = stcs_pkg::reg_idx_t'(cfg_paddr[4:2]);
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable         <= 1'b0;
      cfg_r.window_start   <= '0;
      cfg_r.window_end     <= stcs_pkg::MOD_W'(1439);
      cfg_r.trigger_minute <= '0;
      cfg_r.lock_only      <= 1'b0;
      cfg_r.scheduled_full <= 1'b1;
    end else if (wr_en) begin
      case (idx)
        stcs_pkg::REG_ENABLE:         cfg_r.enable <= cfg_pwdata[0];
        stcs_pkg::REG_WINDOW_START:   cfg_r.window_start <= cfg_pwdata[10:0];
        stcs_pkg::REG_WINDOW_END:     cfg_r.window_end <= cfg_pwdata[10:0];
        stcs_pkg::REG_TRIGGER_MINUTE: cfg_r.trigger_minute <= cfg_pwdata[5:0];
        stcs_pkg::REG_LOCK_ONLY:      cfg_r.lock_only <= cfg_pwdata[0];
        stcs_pkg::REG_SCHEDULED_FULL: cfg_r.scheduled_full <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    cfg_prdata = '0;
    case (idx)
      stcs_pkg::REG_ENABLE:         cfg_prdata[0] = cfg_r.enable;
      stcs_pkg::REG_WINDOW_START:   cfg_prdata[10:0] = cfg_r.window_start;
      stcs_pkg::REG_WINDOW_END:     cfg_prdata[10:0] = cfg_r.window_end;
      stcs_pkg::REG_TRIGGER_MINUTE: cfg_prdata[5:0] = cfg_r.trigger_minute;
      stcs_pkg::REG_LOCK_ONLY:      cfg_prdata[0] = cfg_r.lock_only;
      stcs_pkg::REG_SCHEDULED_FULL: cfg_prdata[0] = cfg_r.scheduled_full;
      default:                      cfg_prdata = '0;
    endcase
  end

endmodule

### rtl/stcs_step.sv
module stcs_step (
  input  stcs_pkg::cfg_t       cfg,
  input  stcs_pkg::req_item_t  item,
  input  stcs_pkg::seq_state_t cur,
  output stcs_pkg::seq_state_t nxt,
  output stcs_pkg::result_t    res
);

  logic [stcs_pkg::MOD_W-1:0]  mod;
  logic                        sched_ok;
  logic                        start_go;
  logic                        start_full;
  logic [stcs_pkg::HOUR_W-1:0] h;
  logic [stcs_pkg::MIN_W-1:0]  m;
  logic [2:0]                  tens;
  logic [stcs_pkg::MIN_W-1:0]  tens_x10;
  logic [stcs_pkg::MIN_W-1:0]  unit;
  logic                        is_teen;

  // minute of day: hour*60 + minute
  assign mod = {item.hour, 6'b0} - {4'b0, item.hour, 2'b0} + {5'b0, item.minute};

  // scheduled check conditions
  assign sched_ok = cfg.enable && (mod <= cfg.window_end) && (mod >= cfg.window_start)
                    && (item.minute == cfg.trigger_minute) && !item.calling
                    && !(cfg.lock_only && item.unlocked);

  assign start_go   = !item.media_busy &&
                      ((item.req_type == stcs_pkg::REQ_START) ||
                       ((item.req_type == stcs_pkg::REQ_CHECK) && sched_ok));
  assign start_full = (item.req_type == stcs_pkg::REQ_START) ? item.full_request
                                                             : cfg.scheduled_full;

  // held time split into digits
  assign h        = cur.hour;
  assign m        = cur.minute;
  assign tens     = stcs_pkg::min_tens(m);
  assign tens_x10 = {tens, 3'b0} + {2'b0, tens, 1'b0};
  assign unit     = m - tens_x10;
  assign is_teen  = (tens == 3'd1);

  // next chain position and held time
  always_comb begin
    nxt = cur;
    case (item.req_type)
      stcs_pkg::REQ_START, stcs_pkg::REQ_CHECK: begin
        if (start_go) begin
          nxt.hour   = (item.hour > stcs_pkg::HOUR_MAX) ? stcs_pkg::HOUR_MAX : item.hour;
          nxt.minute = (item.minute > stcs_pkg::MIN_MAX) ? stcs_pkg::MIN_MAX : item.minute;
          nxt.step   = start_full ? stcs_pkg::STEP_HOUR_NUM : stcs_pkg::STEP_IDLE;
        end
      end
      stcs_pkg::REQ_REPORT: begin
        if (!item.report_matches) begin
          nxt.step = stcs_pkg::STEP_IDLE;
        end else if (item.report_final) begin
          case (cur.step)
            stcs_pkg::STEP_HOUR_NUM:  nxt.step = stcs_pkg::STEP_HOUR_WORD;
            stcs_pkg::STEP_HOUR_WORD: nxt.step = stcs_pkg::STEP_MIN_TENS;
            stcs_pkg::STEP_MIN_TENS: begin
              if (tens == 3'd0)
                nxt.step = (m == '0) ? stcs_pkg::STEP_IDLE : stcs_pkg::STEP_MIN_WORD;
              else if (is_teen || unit == '0)
                nxt.step = stcs_pkg::STEP_MIN_WORD;
              else
                nxt.step = stcs_pkg::STEP_MIN_UNIT;
            end
            stcs_pkg::STEP_MIN_UNIT:
              nxt.step = (m == '0) ? stcs_pkg::STEP_IDLE : stcs_pkg::STEP_MIN_WORD;
            stcs_pkg::STEP_MIN_WORD:  nxt.step = stcs_pkg::STEP_IDLE;
            default:                  nxt.step = stcs_pkg::STEP_IDLE;
          endcase
        end
      end
      default: ;
    endcase
  end

  // clip choice
  always_comb begin
    res = '0;
    case (item.req_type)
      stcs_pkg::REQ_START, stcs_pkg::REQ_CHECK: begin
        if (start_go) begin
          res.valid   = 1'b1;
          res.clip_id = start_full ? stcs_pkg::CLIP_INTRO : stcs_pkg::CLIP_CHIMES;
          res.last    = !start_full;
        end
      end
      stcs_pkg::REQ_REPORT: begin
        if (item.report_matches && item.report_final) begin
          res.valid = 1'b1;
          case (cur.step)
            stcs_pkg::STEP_HOUR_NUM: begin
              if (h == 5'd1)      res.clip_id = stcs_pkg::CLIP_HOUR_ONE;
              else if (h == 5'd2) res.clip_id = stcs_pkg::CLIP_HOUR_TWO;
              else                res.clip_id = {2'b0, h};
            end
            stcs_pkg::STEP_HOUR_WORD: begin
              if (h == 5'd1 || h == 5'd21)
                res.clip_id = stcs_pkg::CLIP_HOUR_SING;
              else if ((h >= 5'd2 && h <= 5'd4) || h == 5'd22 || h == 5'd23)
                res.clip_id = stcs_pkg::CLIP_HOUR_FEW;
              else
                res.clip_id = stcs_pkg::CLIP_HOUR_MANY;
            end
            stcs_pkg::STEP_MIN_TENS, stcs_pkg::STEP_MIN_UNIT: begin
              if (cur.step == stcs_pkg::STEP_MIN_TENS && tens != 3'd0) begin
                // teens and round tens speak the whole number
                if (is_teen || unit == '0) res.clip_id = {1'b0, m};
                else                       res.clip_id = {1'b0, tens_x10};
              end else if (m == '0) begin
                res.clip_id = stcs_pkg::CLIP_EXACTLY;
                res.last    = 1'b1;
              end else if (unit == 6'd1) begin
                res.clip_id = stcs_pkg::CLIP_MIN_ONE;
              end else if (unit == 6'd2) begin
                res.clip_id = stcs_pkg::CLIP_MIN_TWO;
              end else begin
                res.clip_id = {1'b0, unit};
              end
            end
            stcs_pkg::STEP_MIN_WORD: begin
              res.last = 1'b1;
              if (is_teen)                         res.clip_id = stcs_pkg::CLIP_MIN_MANY;
              else if (unit == 6'd1)               res.clip_id = stcs_pkg::CLIP_MIN_SING;
              else if (unit >= 6'd2 && unit <= 6'd4) res.clip_id = stcs_pkg::CLIP_MIN_FEW;
              else                                 res.clip_id = stcs_pkg::CLIP_MIN_MANY;
            end
            default: res.valid = 1'b0;
          endcase
        end
      end
      default: ;
    endcase
  end

endmodule

### rtl/spoken_time_clip_sequencer_core.sv
// a result passes the input register, then the output register, before it is shown;
// requests that cause no clip leave no result
// throughput: one request per cycle; the input register holds only while a
// finished clip waits in the output register and the next request also makes one
// reset: synchronous, active low; chain idle, held time zero, registers at defaults
module spoken_time_clip_sequencer_core (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // hour[4:0], minute[10:5], full_request[11], media_busy[12], calling[13],
  // unlocked[14], report_matches[15], report_final[16], zero fill [23:17]
  input  logic [23:0]                     in_tdata,
  // req_type[1:0]
  input  logic [1:0]                      in_tuser,
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // clip_id[6:0], zero fill [7]
  output logic [7:0]                      out_tdata,
  output logic                            out_tlast,
  // configuration port
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [stcs_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [stcs_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [stcs_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);

  stcs_pkg::cfg_t       cfg;
  stcs_pkg::req_item_t  item_r;
  stcs_pkg::req_item_t  item_nxt;
  logic                 in_valid_r;
  stcs_pkg::seq_state_t state_r;
  stcs_pkg::seq_state_t state_nxt;
  stcs_pkg::result_t    res;
  logic                 out_valid_r;
  logic [stcs_pkg::CLIP_W-1:0] out_clip_r;
  logic                 out_last_r;
  logic                 proc_fire;

  stcs_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  stcs_step u_step (
    .cfg  (cfg),
    .item (item_r),
    .cur  (state_r),
    .nxt  (state_nxt),
    .res  (res)
  );

  // unpack the incoming request
  always_comb begin
    item_nxt.req_type       = stcs_pkg::req_t'(in_tuser);
    item_nxt.hour           = in_tdata[4:0];
    item_nxt.minute         = in_tdata[10:5];
    item_nxt.full_request   = in_tdata[11];
    item_nxt.media_busy     = in_tdata[12];
    item_nxt.calling        = in_tdata[13];
    item_nxt.unlocked       = in_tdata[14];
    item_nxt.report_matches = in_tdata[15];
    item_nxt.report_final   = in_tdata[16];
  end

  // held request is processed unless its clip has nowhere to go
  assign proc_fire = in_valid_r && (!res.valid || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || proc_fire;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= item_nxt;
    end
  end

  // chain state and held time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.step   <= stcs_pkg::STEP_IDLE;
      state_r.hour   <= '0;
      state_r.minute <= '0;
    end else if (proc_fire) begin
      state_r <= state_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc_fire && res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && res.valid) begin
      out_clip_r <= res.clip_id;
      out_last_r <= res.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_clip_r};
  assign out_tlast  = out_last_r;

`ifndef NO_ASSERTIONS
  // latched time always saturated
  a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.hour <= stcs_pkg::HOUR_MAX && state_r.minute <= stcs_pkg::MIN_MAX)
    else $error("held time out of range");

  // a held request is never dropped while stalled
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !proc_fire |=> in_valid_r && $stable(item_r))
    else $error("stalled request lost");

  // a closing clip leaves the chain idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    proc_fire && res.valid && res.last |=> state_r.step == stcs_pkg::STEP_IDLE)
    else $error("chain not idle after closing clip");

  // chimes close an announcement, the intro never does
  a_chimes_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[6:0] == stcs_pkg::CLIP_CHIMES |-> out_tlast)
    else $error("chimes clip without last");

  a_intro_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[6:0] == stcs_pkg::CLIP_INTRO |-> !out_tlast)
    else $error("intro clip marked last");
`endif

endmodule
